// ----- hw/rtl/rse_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rse_pkg;

  localparam int MaxParityDef = 32;
  localparam int SymW         = 8;
  localparam int PcW          = 6;
  localparam int PaddrW       = 3;
  localparam int PdataW       = 32;

  localparam logic [PcW-1:0]  PARITY_COUNT_RESET = 6'd16;
  // low byte of the field polynomial 0x11d
  localparam logic [SymW-1:0] FIELD_POLY_LOW     = 8'h1d;
  localparam logic [SymW-1:0] GF_ONE             = 8'h01;

  // register word index, taken from paddr[2]
  localparam logic REG_PARITY_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_BUILD,
    ST_RUN,
    ST_PAR
  } state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ABSORB,
    CELL_SHIFT,
    CELL_CLR_REM,
    CELL_INIT,
    CELL_BUILD
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e      mode;
    logic [SymW-1:0] fb;
    logic [SymW-1:0] root;
  } cell_ctrl_t;

  function automatic logic [SymW-1:0] gf_xtime(input logic [SymW-1:0] x);
    return {x[SymW-2:0], 1'b0} ^ (x[SymW-1] ? FIELD_POLY_LOW : '0);
  endfunction

  function automatic logic [SymW-1:0] gf_mul(input logic [SymW-1:0] a,
                                             input logic [SymW-1:0] b);
    logic [SymW-1:0] acc;
    logic [SymW-1:0] x;
    acc = '0;
    x   = a;
    for (int k = 0; k < SymW; k++) begin
      if (b[k]) acc = acc ^ x;
      x = gf_xtime(x);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rse_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rse_cell (
  input  wire logic                      clk_i,
  input  wire rse_pkg::cell_ctrl_t       ctrl_i,
  input  wire logic [rse_pkg::SymW-1:0]  r_next_i,
  input  wire logic [rse_pkg::SymW-1:0]  g_prev_i,
  output logic      [rse_pkg::SymW-1:0]  r_o,
  output logic      [rse_pkg::SymW-1:0]  g_o
);

  logic [rse_pkg::SymW-1:0] r_q, r_d;
  logic [rse_pkg::SymW-1:0] g_q, g_d;
  logic [rse_pkg::SymW-1:0] mul_a, mul_b, prod;

  // one multiplier, shared between encoding and generator build
  always_comb begin
    if (ctrl_i.mode == rse_pkg::CELL_BUILD) begin
      mul_a = g_prev_i;
      mul_b = ctrl_i.root;
    end else begin
      mul_a = ctrl_i.fb;
      mul_b = g_q;
    end
    prod = rse_pkg::gf_mul(mul_a, mul_b);
  end

  always_comb begin
    r_d = r_q;
    g_d = g_q;
    case (ctrl_i.mode)
      rse_pkg::CELL_HOLD:    ;
      rse_pkg::CELL_ABSORB:  r_d = r_next_i ^ prod;
      rse_pkg::CELL_SHIFT:   r_d = r_next_i;
      rse_pkg::CELL_CLR_REM: r_d = '0;
      rse_pkg::CELL_INIT: begin
        r_d = '0;
        g_d = '0;
      end
      rse_pkg::CELL_BUILD:   g_d = g_q ^ prod;
      default:               ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    g_q <= g_d;
  end

  assign r_o = r_q;
  assign g_o = g_q;

endmodule

`default_nettype wire

// ----- hw/rtl/reed_solomon_systematic_encoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Systematic RS encoder over GF(256), generator roots 2^0 .. 2^(P-1).
// Input channel (in_valid_i / in_stall_o) carries message symbols, first symbol
// highest degree, msg_last_i on the final one. Output channel (out_valid_o /
// out_stall_i) returns each symbol echoed in the cycle after it is taken, then,
// after the last symbol, P parity symbols, highest degree first, codeword_last_o
// on the final one. Message symbols go in at one item per cycle while in_stall_o
// is low; after the last symbol of a message with parity, in_stall_o stays high
// while the row of cells shifts out the remainder. Messages longer than 255 - P
// symbols get no parity: the last echo carries codeword_last_o and length_error_o.
// parity_count sits at byte address 0 of the APB port (reset 16, saturated to
// MAX_PARITY). Writing it rebuilds the generator in the cells, one root per
// cycle: in_stall_o is high in the write cycle and through the clear and build
// that follow. A write in mid-message is held until that message ends. After
// reset the same build runs. While out_stall_i holds a result, the single output
// register stays full and in_stall_o is raised; nothing is lost or repeated.
module reed_solomon_systematic_encoder_unit #(
  parameter int MAX_PARITY = rse_pkg::MaxParityDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rse_pkg::PaddrW-1:0]    paddr,
  input  wire logic [rse_pkg::PdataW-1:0]    pwdata,
  output logic      [rse_pkg::PdataW-1:0]    prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [rse_pkg::SymW-1:0]      msg_symbol_i,
  input  wire logic                          msg_last_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [rse_pkg::SymW-1:0]      code_symbol_o,
  output logic                               is_parity_o,
  output logic                               codeword_last_o,
  output logic                               length_error_o
);

  localparam int NW = $clog2(MAX_PARITY + 1);
  localparam int SW = rse_pkg::SymW;

  rse_pkg::state_e           state_q, state_d;
  logic [rse_pkg::PcW-1:0]   pc_q, pc_d;
  logic                      pend_q, pend_d;
  logic [NW-1:0]             n_q, n_d, n_sat;
  logic [SW-1:0]             cnt_q, cnt_d, cnt_inc;
  logic                      ovf_q, ovf_d, ovf_new;
  logic [NW-1:0]             step_q, step_d;
  logic [SW-1:0]             root_q, root_d;

  logic                      ov_q, ov_d;
  logic [SW-1:0]             osym_q, osym_d;
  logic                      opar_q, opar_d;
  logic                      olast_q, olast_d;
  logic                      oerr_q, oerr_d;

  logic                      cfg_wr;
  logic                      can_load;
  logic                      acc;
  logic                      err;
  rse_pkg::cell_ctrl_t       ctrl;

  logic [SW-1:0]             rem_w [MAX_PARITY];
  logic [SW-1:0]             gen_w [MAX_PARITY];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rse_pkg::REG_PARITY_COUNT);
  assign prdata = (paddr[2] == rse_pkg::REG_PARITY_COUNT)
                  ? {{(rse_pkg::PdataW - rse_pkg::PcW){1'b0}}, pc_q} : '0;

  assign n_sat = ({2'b00, pc_q} > 8'(MAX_PARITY)) ? NW'(MAX_PARITY) : NW'(pc_q);

  assign can_load   = !ov_q || !out_stall_i;
  assign in_stall_o = !((state_q == rse_pkg::ST_RUN) && can_load && !cfg_wr);
  assign acc        = in_valid_i && !in_stall_o;

  assign cnt_inc = (cnt_q == 8'hff) ? cnt_q : cnt_q + 8'd1;
  assign ovf_new = ovf_q || (cnt_q == 8'hff);
  assign err     = ovf_new || ((9'(cnt_inc) + 9'(n_q)) > 9'd255);

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    pend_d    = pend_q;
    n_d       = n_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    step_d    = step_q;
    root_d    = root_q;
    ov_d      = ov_q && out_stall_i;
    osym_d    = osym_q;
    opar_d    = opar_q;
    olast_d   = olast_q;
    oerr_d    = oerr_q;
    ctrl.mode = rse_pkg::CELL_HOLD;
    ctrl.fb   = msg_symbol_i ^ rem_w[0];
    ctrl.root = root_q;

    case (state_q)
      rse_pkg::ST_CLEAR: begin
        ctrl.mode = rse_pkg::CELL_INIT;
        n_d       = n_sat;
        pend_d    = 1'b0;
        step_d    = '0;
        root_d    = rse_pkg::GF_ONE;
        state_d   = rse_pkg::ST_BUILD;
      end
      rse_pkg::ST_BUILD: begin
        if (step_q == n_q) begin
          state_d = rse_pkg::ST_RUN;
        end else begin
          ctrl.mode = rse_pkg::CELL_BUILD;
          root_d    = rse_pkg::gf_xtime(root_q);
          step_d    = step_q + 1'b1;
        end
      end
      rse_pkg::ST_RUN: begin
        if (acc) begin
          ov_d    = 1'b1;
          osym_d  = msg_symbol_i;
          opar_d  = 1'b0;
          olast_d = 1'b0;
          oerr_d  = 1'b0;
          if (!msg_last_i) begin
            ctrl.mode = rse_pkg::CELL_ABSORB;
            cnt_d     = cnt_inc;
            ovf_d     = ovf_new;
          end else begin
            cnt_d = '0;
            ovf_d = 1'b0;
            if (err || (n_q == '0)) begin
              // no parity: the echo closes the codeword
              ctrl.mode = rse_pkg::CELL_CLR_REM;
              olast_d   = 1'b1;
              oerr_d    = err;
              if (pend_q) state_d = rse_pkg::ST_CLEAR;
            end else begin
              ctrl.mode = rse_pkg::CELL_ABSORB;
              step_d    = '0;
              state_d   = rse_pkg::ST_PAR;
            end
          end
        end
      end
      rse_pkg::ST_PAR: begin
        if (can_load) begin
          // shifting in zeros leaves the remainder clear after the last one
          ctrl.mode = rse_pkg::CELL_SHIFT;
          ov_d      = 1'b1;
          osym_d    = rem_w[0];
          opar_d    = 1'b1;
          oerr_d    = 1'b0;
          olast_d   = (step_q == NW'(n_q - 1'b1));
          step_d    = step_q + 1'b1;
          if (step_q == NW'(n_q - 1'b1)) begin
            state_d = pend_q ? rse_pkg::ST_CLEAR : rse_pkg::ST_RUN;
          end
        end
      end
      default: state_d = rse_pkg::ST_CLEAR;
    endcase

    if (cfg_wr) begin
      pc_d = pwdata[rse_pkg::PcW-1:0];
      // a write on the last parity item rebuilds right away
      if ((cnt_q != '0) ||
          ((state_q == rse_pkg::ST_PAR) && (state_d == rse_pkg::ST_PAR))) begin
        pend_d = 1'b1;
      end else begin
        state_d = rse_pkg::ST_CLEAR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rse_pkg::ST_CLEAR;
      pc_q    <= rse_pkg::PARITY_COUNT_RESET;
      pend_q  <= 1'b0;
      n_q     <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      step_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      pend_q  <= pend_d;
      n_q     <= n_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      step_q  <= step_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q  <= root_d;
    osym_q  <= osym_d;
    opar_q  <= opar_d;
    olast_q <= olast_d;
    oerr_q  <= oerr_d;
  end

  for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
    logic [SW-1:0] r_next;
    logic [SW-1:0] g_prev;
    if (j == MAX_PARITY - 1) begin : g_tail
      assign r_next = '0;
    end else begin : g_mid
      assign r_next = rem_w[j+1];
    end
    if (j == 0) begin : g_head
      assign g_prev = rse_pkg::GF_ONE;
    end else begin : g_body
      assign g_prev = gen_w[j-1];
    end
    rse_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .r_next_i (r_next),
      .g_prev_i (g_prev),
      .r_o      (rem_w[j]),
      .g_o      (gen_w[j])
    );
  end

  assign out_valid_o     = ov_q;
  assign code_symbol_o   = osym_q;
  assign is_parity_o     = opar_q;
  assign codeword_last_o = olast_q;
  assign length_error_o  = oerr_q;

`ifndef SYNTHESIS
  a_par_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_parity_o |-> !length_error_o)
    else $error("parity item flagged with length error");

  a_par_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rse_pkg::ST_PAR) |-> (step_q < n_q))
    else $error("parity index ran past parity count");

  a_enter_par: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && msg_last_i && !err && (n_q != '0) && !cfg_wr |=> (state_q == rse_pkg::ST_PAR))
    else $error("last symbol without error did not start parity");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_error_o |-> codeword_last_o)
    else $error("length error on an item that does not close the codeword");
`endif

endmodule

`default_nettype wire
